FILE: rtl/reliable_datagram_ack_window_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the reliable datagram ack window core
// Concurrent assertion wrappers shared by the checker.
// ---------------------------------------------------------------------------
`ifndef RELIABLE_DATAGRAM_ACK_WINDOW_CORE_MACROS_SVH
`define RELIABLE_DATAGRAM_ACK_WINDOW_CORE_MACROS_SVH

// check a property outside of reset
`define RDAW_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check a property on every edge, reset included
`define RDAW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/rdaw_pkg.sv
// ---------------------------------------------------------------------------
// rdaw_pkg
// Types and constants of the reliable datagram ack window core.
// ---------------------------------------------------------------------------
package rdaw_pkg;

   localparam int HISTORY_DEPTH_DEFAULT = 32;
   localparam int RESULT_CAP = 32;
   localparam int WINDOW = 32;
   localparam logic [15:0] HALF_RANGE = 16'd32768;
   localparam logic [9:0] AGE_MAX = 10'd1023;
   localparam logic [9:0] TIMEOUT_RESET = 10'd100;
   localparam logic [3:0] RETRIES_RESET = 4'd15;

   typedef enum logic [1:0] {
      OP_RECEIVE = 2'd0,
      OP_SEND    = 2'd1,
      OP_TICK    = 2'd2,
      OP_UNUSED  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_VERDICT    = 2'd0,
      KIND_STAMP      = 2'd1,
      KIND_RETRANSMIT = 2'd2,
      KIND_GIVEN_UP   = 2'd3
   } kind_type;

   typedef enum logic {
      CSR_TIMEOUT     = 1'b0,
      CSR_MAX_RETRIES = 1'b1
   } csr_index_type;

   typedef struct packed {
      op_type      op;
      logic [15:0] seq;
      logic [15:0] ack;
      logic [31:0] bits;
      logic        reliable;
   } item_type;

   typedef struct packed {
      logic [15:0] seq;
      logic [9:0]  age;
      logic [3:0]  retries;
   } entry_type;

endpackage

FILE: rtl/rdaw_front.sv
// ---------------------------------------------------------------------------
// rdaw_front
// Accepts items, drops unused operations, queues the rest for the back end.
// ---------------------------------------------------------------------------
module rdaw_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  rdaw_pkg::item_type req_item,
   output logic               q_valid,
   output rdaw_pkg::item_type q_item,
   input  logic               q_pop
);
   import rdaw_pkg::*;

   item_type   q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready && (req_item.op != OP_UNUSED);
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= req_item;
      end
   end

endmodule

FILE: rtl/rdaw_back.sv
// ---------------------------------------------------------------------------
// rdaw_back
// Executes queued items: receive window, ack freeing, send records, tick scan.
// ---------------------------------------------------------------------------
module rdaw_back #(
   parameter int HISTORY_DEPTH = rdaw_pkg::HISTORY_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [9:0]         csr_write_data,
   input  logic               q_valid,
   input  rdaw_pkg::item_type q_item,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_result_kind,
   output logic [15:0]        rsp_seq,
   output logic [15:0]        rsp_ack_out,
   output logic [31:0]        rsp_ack_bits_out,
   output logic               rsp_duplicate,
   output logic               rsp_table_full,
   output logic               rsp_last
);
   import rdaw_pkg::*;

   localparam int IDXW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNTW = $clog2(HISTORY_DEPTH + 1);
   localparam int NW   = $clog2(RESULT_CAP + 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_READ   = 4'b0010,
      ST_EVAL   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNTW-1:0]    idx_ff, idx_in;
   item_type           item_ff, item_in;
   logic               dup_ff, dup_in;
   logic [15:0]        latest_ff, latest_in;
   logic [31:0]        hist_ff, hist_in;
   logic [15:0]        sendseq_ff, sendseq_in;
   logic [HISTORY_DEPTH-1:0] valid_ff, valid_in;
   logic               match_ff, match_in;
   logic               free_ff, free_in;
   logic [IDXW-1:0]    slot_ff, slot_in;
   logic               pend_ff, pend_in;
   kind_type           pend_kind_ff, pend_kind_in;
   logic [15:0]        pend_seq_ff, pend_seq_in;
   logic [NW-1:0]      count_ff, count_in;
   logic [9:0]         timeout_ff;
   logic [3:0]         maxret_ff;
   entry_type          mem [HISTORY_DEPTH];
   entry_type          rd_data_ff;
   logic               wr_en;
   logic [IDXW-1:0]    wr_addr;
   entry_type          wr_data;
   logic [IDXW-1:0]    idx;

   logic               rsp_valid_ff, rsp_valid_in;
   kind_type           rsp_kind_ff, rsp_kind_in;
   logic [15:0]        rsp_seq_ff, rsp_seq_in;
   logic [15:0]        rsp_ack_ff, rsp_ack_in;
   logic [31:0]        rsp_bits_ff, rsp_bits_in;
   logic               rsp_dup_ff, rsp_dup_in;
   logic               rsp_full_ff, rsp_full_in;
   logic               rsp_last_ff, rsp_last_in;

   // receive window math
   logic [15:0] fwd, back, dfree;
   logic [4:0]  fwd_m1, back_m1, dfree_m1;
   logic [31:0] rx_hist;
   logic [15:0] rx_latest;
   logic        rx_dup;
   logic        out_free;
   logic        expired, freeable;
   logic [9:0]  age_next;

   assign idx      = idx_ff[IDXW-1:0];
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      fwd       = q_item.seq - latest_ff;
      back      = latest_ff - q_item.seq;
      fwd_m1    = 5'(fwd - 16'd1);
      back_m1   = 5'(back - 16'd1);
      rx_hist   = hist_ff;
      rx_latest = latest_ff;
      rx_dup    = 1'b0;
      if (q_item.seq == latest_ff) begin
         rx_dup = 1'b1;
      end else if (fwd < HALF_RANGE) begin
         rx_hist = (fwd < 16'(WINDOW)) ? (hist_ff << fwd[4:0]) : 32'd0;
         if (fwd <= 16'(WINDOW)) begin
            rx_hist = rx_hist | (32'd1 << fwd_m1);
         end
         rx_latest = q_item.seq;
      end else if (back <= 16'(WINDOW)) begin
         rx_dup  = hist_ff[back_m1];
         rx_hist = hist_ff | (32'd1 << back_m1);
      end else begin
         rx_dup = 1'b1;
      end
   end

   always_comb begin
      dfree    = item_ff.ack - rd_data_ff.seq;
      dfree_m1 = 5'(dfree - 16'd1);
      freeable = (dfree == 16'd0) ||
                 ((dfree <= 16'(WINDOW)) && item_ff.bits[dfree_m1]);
      expired  = (rd_data_ff.age >= timeout_ff);
      age_next = (rd_data_ff.age == AGE_MAX) ? AGE_MAX : rd_data_ff.age + 10'd1;
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      item_in      = item_ff;
      dup_in       = dup_ff;
      latest_in    = latest_ff;
      hist_in      = hist_ff;
      sendseq_in   = sendseq_ff;
      valid_in     = valid_ff;
      match_in     = match_ff;
      free_in      = free_ff;
      slot_in      = slot_ff;
      pend_in      = pend_ff;
      pend_kind_in = pend_kind_ff;
      pend_seq_in  = pend_seq_ff;
      count_in     = count_ff;
      q_pop        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = idx;
      wr_data      = rd_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_seq_in   = rsp_seq_ff;
      rsp_ack_in   = rsp_ack_ff;
      rsp_bits_in  = rsp_bits_ff;
      rsp_dup_in   = rsp_dup_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               item_in  = q_item;
               idx_in   = '0;
               match_in = 1'b0;
               free_in  = 1'b0;
               pend_in  = 1'b0;
               count_in = '0;
               state_in = ST_READ;
               case (q_item.op)
                  OP_RECEIVE: begin
                     latest_in = rx_latest;
                     hist_in   = rx_hist;
                     dup_in    = rx_dup;
                  end
                  OP_SEND: begin
                     sendseq_in = sendseq_ff + 16'd1;
                     if (!q_item.reliable) begin
                        state_in = ST_FINISH;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            if (idx_ff == CNTW'(HISTORY_DEPTH)) begin
               state_in = ST_FINISH;
            end else if (valid_ff[idx]) begin
               state_in = ST_EVAL;
            end else begin
               if (item_ff.op == OP_SEND && !free_ff) begin
                  free_in = 1'b1;
                  slot_in = idx;
               end
               idx_in = idx_ff + CNTW'(1);
            end
         end
         ST_EVAL: begin
            state_in = ST_READ;
            idx_in   = idx_ff + CNTW'(1);
            case (item_ff.op)
               OP_RECEIVE: begin
                  if (freeable) begin
                     valid_in[idx] = 1'b0;
                  end
               end
               OP_SEND: begin
                  if (rd_data_ff.seq == sendseq_ff) begin
                     match_in = 1'b1;
                     slot_in  = idx;
                     state_in = ST_FINISH;
                  end
               end
               default: begin
                  wr_data.age = age_next;
                  if (expired && count_ff < NW'(RESULT_CAP)) begin
                     if (pend_ff && !out_free) begin
                        // hold until the earlier result can leave
                        state_in = ST_EVAL;
                        idx_in   = idx_ff;
                     end else begin
                        if (pend_ff) begin
                           rsp_valid_in = 1'b1;
                           rsp_kind_in  = pend_kind_ff;
                           rsp_seq_in   = pend_seq_ff;
                           rsp_ack_in   = latest_ff;
                           rsp_bits_in  = hist_ff;
                           rsp_dup_in   = 1'b0;
                           rsp_full_in  = 1'b0;
                           rsp_last_in  = 1'b0;
                        end
                        pend_in     = 1'b1;
                        pend_seq_in = rd_data_ff.seq;
                        count_in    = count_ff + NW'(1);
                        wr_en       = 1'b1;
                        if (rd_data_ff.retries < maxret_ff) begin
                           pend_kind_in    = KIND_RETRANSMIT;
                           wr_data.age     = 10'd0;
                           wr_data.retries = rd_data_ff.retries + 4'd1;
                        end else begin
                           pend_kind_in  = KIND_GIVEN_UP;
                           valid_in[idx] = 1'b0;
                        end
                     end
                  end else begin
                     wr_en = 1'b1;
                  end
               end
            endcase
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in    = ST_IDLE;
               rsp_ack_in  = latest_ff;
               rsp_bits_in = hist_ff;
               rsp_dup_in  = 1'b0;
               rsp_full_in = 1'b0;
               rsp_last_in = 1'b1;
               case (item_ff.op)
                  OP_RECEIVE: begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_VERDICT;
                     rsp_seq_in   = item_ff.seq;
                     rsp_dup_in   = dup_ff;
                  end
                  OP_SEND: begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_STAMP;
                     rsp_seq_in   = sendseq_ff;
                     if (item_ff.reliable) begin
                        if (match_ff || free_ff) begin
                           wr_en             = 1'b1;
                           wr_addr           = slot_ff;
                           wr_data.seq       = sendseq_ff;
                           wr_data.age       = 10'd0;
                           wr_data.retries   = 4'd0;
                           valid_in[slot_ff] = 1'b1;
                        end else begin
                           rsp_full_in = 1'b1;
                        end
                     end
                  end
                  default: begin
                     rsp_valid_in = pend_ff;
                     rsp_kind_in  = pend_kind_ff;
                     rsp_seq_in   = pend_seq_ff;
                  end
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         latest_ff    <= '0;
         hist_ff      <= '0;
         sendseq_ff   <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         timeout_ff   <= TIMEOUT_RESET;
         maxret_ff    <= RETRIES_RESET;
      end else begin
         state_ff     <= state_in;
         latest_ff    <= latest_in;
         hist_ff      <= hist_in;
         sendseq_ff   <= sendseq_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_TIMEOUT:     timeout_ff <= csr_write_data;
               CSR_MAX_RETRIES: maxret_ff  <= csr_write_data[3:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      item_ff      <= item_in;
      dup_ff       <= dup_in;
      match_ff     <= match_in;
      free_ff      <= free_in;
      slot_ff      <= slot_in;
      pend_ff      <= pend_in;
      pend_kind_ff <= pend_kind_in;
      pend_seq_ff  <= pend_seq_in;
      count_ff     <= count_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_seq_ff   <= rsp_seq_in;
      rsp_ack_ff   <= rsp_ack_in;
      rsp_bits_ff  <= rsp_bits_in;
      rsp_dup_ff   <= rsp_dup_in;
      rsp_full_ff  <= rsp_full_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[idx];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = rsp_kind_ff;
   assign rsp_seq          = rsp_seq_ff;
   assign rsp_ack_out      = rsp_ack_ff;
   assign rsp_ack_bits_out = rsp_bits_ff;
   assign rsp_duplicate    = rsp_dup_ff;
   assign rsp_table_full   = rsp_full_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

FILE: rtl/reliable_datagram_ack_window_core.sv
// ---------------------------------------------------------------------------
// reliable_datagram_ack_window_core
// Sequence and acknowledgement engine for reliable datagrams.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one item: receive (seq, ack, ack bitfield), send (reliable
//   flag) or tick. rsp_* returns result items; rsp_last marks the final result
//   of an item. csr_* writes timeout_ticks (index 0) and max_retries
//   (index 1); the user must write them only while the block is idle,
//   which the block itself does not enforce.
//   A two-item queue sits between the front end and the executing back end;
//   an accepted item is registered into the queue, whose head the back end
//   reads. An unreliable send goes from the queue head straight to its
//   final result. Receive, reliable send and tick walk the entry table after
//   taking the item: a free slot is skipped in a read step, a live slot gets
//   a registered memory read, then an evaluate step; an end check and the
//   issue of the last result follow. A reliable send stops early at a live
//   entry with the same sequence. Items run one at a time over the entry
//   memory, which has one read and one write port.
//   A tick with nothing expired gives no result; operation 3 gives none.
//   Reset clears the window, the send counter, all entry valid bits and
//   restores the register defaults; no clearing pass is needed.
//   A stalled receiver holds the result register; a tick scan then waits, and
//   the queue keeps accepting items until it fills.
// ---------------------------------------------------------------------------
module reliable_datagram_ack_window_core #(
   parameter int HISTORY_DEPTH = rdaw_pkg::HISTORY_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [9:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [15:0] req_packet_seq,
   input  logic [15:0] req_packet_ack,
   input  logic [31:0] req_packet_ack_bits,
   input  logic        req_reliable,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_result_kind,
   output logic [15:0] rsp_seq,
   output logic [15:0] rsp_ack_out,
   output logic [31:0] rsp_ack_bits_out,
   output logic        rsp_duplicate,
   output logic        rsp_table_full,
   output logic        rsp_last
);
   import rdaw_pkg::*;

   item_type req_item, q_item;
   logic     q_valid, q_pop;

   // pack the request fields into one item
   assign req_item = '{op: op_type'(req_operation), seq: req_packet_seq,
                       ack: req_packet_ack, bits: req_packet_ack_bits,
                       reliable: req_reliable};

   rdaw_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   rdaw_back #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_seq          (rsp_seq),
      .rsp_ack_out      (rsp_ack_out),
      .rsp_ack_bits_out (rsp_ack_bits_out),
      .rsp_duplicate    (rsp_duplicate),
      .rsp_table_full   (rsp_table_full),
      .rsp_last         (rsp_last)
   );

endmodule

FILE: rtl/rdaw_checker.sv
// ---------------------------------------------------------------------------
// rdaw_checker
// Port-level checks on the reliable datagram ack window core.
// ---------------------------------------------------------------------------
`include "reliable_datagram_ack_window_core_macros.svh"

module rdaw_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_result_kind,
   input logic [15:0] rsp_seq,
   input logic        rsp_duplicate,
   input logic        rsp_table_full,
   input logic        rsp_last
);
   import rdaw_pkg::*;

   `RDAW_ASSERT_ALWAYS(a_no_rsp_after_reset, clock, $past(reset) |-> !rsp_valid, "rsp after reset")
   `RDAW_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_seq) && $stable(rsp_last), "stalled rsp changed")
   `RDAW_ASSERT(a_dup_only_rx, clock, reset, rsp_valid && rsp_duplicate |-> rsp_result_kind == KIND_VERDICT, "duplicate off receive")
   `RDAW_ASSERT(a_full_only_tx, clock, reset, rsp_valid && rsp_table_full |-> rsp_result_kind == KIND_STAMP && rsp_last, "table_full off send")

endmodule

bind reliable_datagram_ack_window_core rdaw_checker u_rdaw_checker (.*);

FILE: bench/tb_reliable_datagram_ack_window_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the reliable datagram ack window core
// Drives receive, send and tick items through the request channel. A
// behavioral window and entry-table predictor computes every expected
// result, and each response is compared field by field against it.
// ---------------------------------------------------------------------------
module tb_reliable_datagram_ack_window_core;
   import rdaw_pkg::*;

   localparam int DEPTH = 32;
   localparam int CYCLE_LIMIT = 2000000;

   // Result record, kept in arrival order.
   typedef struct packed {
      kind_type    kind;
      logic [15:0] seq;
      logic [15:0] ack;
      logic [31:0] bits;
      logic        dup;
      logic        full;
      logic        last;
   } outcome_type;

   // One row of the directed table; has_expect marks rows with typed results.
   typedef struct {
      op_type      op;
      logic [15:0] seq;
      logic [15:0] ack;
      logic [31:0] bits;
      logic        reliable;
      logic        has_expect;
      outcome_type want;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic        csr_index = 1'b0;
   logic [9:0]  csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_operation = '0;
   logic [15:0] req_packet_seq = '0;
   logic [15:0] req_packet_ack = '0;
   logic [31:0] req_packet_ack_bits = '0;
   logic        req_reliable = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [15:0] rsp_seq;
   logic [15:0] rsp_ack_out;
   logic [31:0] rsp_ack_bits_out;
   logic        rsp_duplicate;
   logic        rsp_table_full;
   logic        rsp_last;

   reliable_datagram_ack_window_core dut (.*);

   // Clock: 12 ns period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---- predictor state -------------------------------------------------
   logic [9:0]  timeout_cfg;
   logic [3:0]  retries_cfg;
   logic [15:0] latest_seq;
   logic [31:0] history;
   logic [15:0] next_send;
   logic        slot_live [DEPTH];
   entry_type   slot_info [DEPTH];

   typedef bit  bool_t;
   outcome_type pending_results[$];
   int          error_count = 0;
   int          result_count = 0;
   int          item_count = 0;
   int          retx_count = 0;
   int          giveup_count = 0;
   int          dup_count = 0;
   int          full_count = 0;
   int          cycle_count = 0;
   bool_t       stall_off;

   function automatic outcome_type make_outcome(kind_type k, logic [15:0] s,
                                                logic d, logic f);
      outcome_type o;
      o.kind = k; o.seq = s; o.ack = latest_seq; o.bits = history;
      o.dup = d; o.full = f; o.last = 1'b0;
      return o;
   endfunction

   // Update the receive window; return the duplicate verdict.
   function automatic logic window_receive(logic [15:0] s);
      logic [15:0] fwd, back;
      logic [31:0] h, m;
      if (s == latest_seq) return 1'b1;
      fwd = s - latest_seq;
      if (fwd < HALF_RANGE) begin
         h = (fwd < WINDOW) ? (history << fwd) : 32'd0;
         if (fwd <= WINDOW) h |= 32'd1 << (fwd - 1);
         history = h;
         latest_seq = s;
         return 1'b0;
      end
      back = latest_seq - s;
      if (back >= 1 && back <= WINDOW) begin
         m = 32'd1 << (back - 1);
         if ((history & m) != 0) return 1'b1;
         history |= m;
         return 1'b0;
      end
      return 1'b1;
   endfunction

   // Work out the results of one item, updating the predictor state.
   task automatic predict_item(op_type op, logic [15:0] s, logic [15:0] a,
                               logic [31:0] b, logic rel, ref outcome_type res[$]);
      logic        dup, full;
      logic [15:0] fwd, back, d;
      logic [31:0] m;
      logic [9:0]  age;
      bit          found;
      int          slot;
      res.delete();
      case (op)
         OP_RECEIVE: begin
            dup = 1'b0;
            if (s == latest_seq) dup = 1'b1;
            else begin
               fwd = s - latest_seq;
               if (fwd < HALF_RANGE) void'(window_receive(s));
               else begin
                  back = latest_seq - s;
                  if (back >= 1 && back <= WINDOW) begin
                     m = 32'd1 << (back - 1);
                     if ((history & m) != 0) dup = 1'b1;
                     history |= m;
                  end else dup = 1'b1;
               end
            end
            // Free every entry the ack or ack bitfield covers.
            for (int i = 0; i < DEPTH; i++) begin
               if (!slot_live[i]) continue;
               d = a - slot_info[i].seq;
               if (d == 0 || (d <= WINDOW && b[d - 1])) slot_live[i] = 1'b0;
            end
            res.push_back(make_outcome(KIND_VERDICT, s, dup, 1'b0));
         end
         OP_SEND: begin
            full = 1'b0;
            next_send = next_send + 16'd1;
            if (rel) begin
               slot = -1;
               for (int i = 0; i < DEPTH; i++)
                  if (slot < 0 && slot_live[i] && slot_info[i].seq == next_send) slot = i;
               for (int i = 0; i < DEPTH; i++)
                  if (slot < 0 && !slot_live[i]) slot = i;
               if (slot < 0) full = 1'b1;
               else begin
                  slot_live[slot] = 1'b1;
                  slot_info[slot] = '{seq: next_send, age: '0, retries: '0};
               end
            end
            res.push_back(make_outcome(KIND_STAMP, next_send, 1'b0, full));
         end
         OP_TICK: begin
            for (int i = 0; i < DEPTH; i++) begin
               if (!slot_live[i]) continue;
               age = slot_info[i].age;
               found = age >= timeout_cfg;
               slot_info[i].age = (age < AGE_MAX) ? age + 10'd1 : AGE_MAX;
               if (!found || res.size() >= RESULT_CAP) continue;
               if (slot_info[i].retries < retries_cfg) begin
                  res.push_back(make_outcome(KIND_RETRANSMIT, slot_info[i].seq,
                                             1'b0, 1'b0));
                  slot_info[i].age = '0;
                  slot_info[i].retries += 4'd1;
               end else begin
                  res.push_back(make_outcome(KIND_GIVEN_UP, slot_info[i].seq,
                                             1'b0, 1'b0));
                  slot_live[i] = 1'b0;
               end
            end
         end
         default: ;
      endcase
      if (res.size() > 0) res[res.size() - 1].last = 1'b1;
   endtask

   // ---- driving ---------------------------------------------------------
   bit sender_idle_on = 1'b1;

   task automatic write_register(csr_index_type idx, logic [9:0] val);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_TIMEOUT) timeout_cfg = val;
      else retries_cfg = val[3:0];
   endtask

   // Present one item, hold it until accepted, and queue its expectations.
   // Valid stays high on return; an idle burst or drain drops it.
   task automatic send_item(op_type op, logic [15:0] s, logic [15:0] a,
                            logic [31:0] b, logic rel, bit typed, outcome_type want);
      outcome_type res[$];
      int gap;
      if (sender_idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 14);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_packet_seq <= s;
      req_packet_ack <= a;
      req_packet_ack_bits <= b;
      req_reliable <= rel;
      predict_item(op, s, a, b, rel, res);
      if (typed && (res.size() != 1 || res[0] != want)) begin
         $error("directed row: predictor disagrees with typed result (seq %0h)", s);
         error_count++;
      end
      foreach (res[i]) pending_results.push_back(res[i]);
      do @(posedge clock); while (!req_ready);
      item_count++;
      @(negedge clock);
   endtask

   // Receiver: random stall bursts until the final stretch.
   always begin
      @(negedge clock);
      if (!stall_off && $urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      rsp_ready <= 1'b1;
   end

   // ---- checking --------------------------------------------------------
   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         outcome_type w;
         result_count <= result_count + 1;
         if (pending_results.size() == 0) begin
            $error("unexpected result: kind %0d seq %0h", rsp_result_kind, rsp_seq);
            error_count++;
         end else begin
            w = pending_results.pop_front();
            check_field("result_kind", w.kind, rsp_result_kind);
            check_field("seq", w.seq, rsp_seq);
            check_field("ack_out", w.ack, rsp_ack_out);
            check_field("ack_bits_out", w.bits, rsp_ack_bits_out);
            check_field("duplicate", w.dup, rsp_duplicate);
            check_field("table_full", w.full, rsp_table_full);
            check_field("last", w.last, rsp_last);
            if (w.kind == KIND_RETRANSMIT) retx_count++;
            if (w.kind == KIND_GIVEN_UP) giveup_count++;
            if (w.dup) dup_count++;
            if (w.full) full_count++;
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_reliable_datagram_ack_window_core failed");
         $finish;
      end
   end

   // Drop valid, wait until the expected results are drained, then let any
   // queued scans without results settle.
   task automatic drain;
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8 * DEPTH + 16) @(posedge clock);
   endtask

   // ---- random stimulus -------------------------------------------------
   task automatic random_items(int count);
      op_type      op;
      logic [15:0] s, a;
      logic [31:0] b;
      int          pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         b = $urandom();
         if (pick < 40) begin
            op = OP_RECEIVE;
            // Mostly near the window so that history bits and acks matter.
            case ($urandom_range(0, 4))
               0: s = latest_seq + 16'($urandom_range(1, 40));
               1: s = latest_seq - 16'($urandom_range(0, 36));
               2: s = 16'($urandom());
               default: s = latest_seq + 16'($urandom_range(1, 3));
            endcase
            if ($urandom_range(0, 3) != 0) a = next_send - 16'($urandom_range(0, 8));
            else a = 16'($urandom());
            if ($urandom_range(0, 2) == 0) b = b & ~($urandom() | $urandom());
         end else if (pick < 75) op = OP_SEND;
         else if (pick < 97) op = OP_TICK;
         else op = OP_UNUSED;
         if (op != OP_RECEIVE) begin
            s = 16'($urandom()); a = 16'($urandom());
         end
         send_item(op, s, a, b, $urandom_range(0, 3) != 0, 1'b0,
                   outcome_type'{kind: KIND_VERDICT, default: 0});
      end
   endtask

   // ---- directed table --------------------------------------------------
   row_type directed[$];

   function automatic outcome_type typed_row(kind_type k, logic [15:0] s, logic [15:0] a,
                                             logic [31:0] b, logic d, logic f);
      return '{kind: k, seq: s, ack: a, bits: b, dup: d, full: f, last: 1'b1};
   endfunction

   initial begin
      outcome_type none;
      none = '{kind: KIND_VERDICT, default: 0};
      stall_off = 1'b0;
      timeout_cfg = TIMEOUT_RESET;
      retries_cfg = RETRIES_RESET;
      latest_seq = '0; history = '0; next_send = '0;
      foreach (slot_live[i]) slot_live[i] = 1'b0;

      // Receive of seq 0 after reset is a duplicate; first send is 1.
      directed.push_back('{OP_RECEIVE, 16'd0, 16'd0, 32'd0, 1'b0, 1'b1,
                           typed_row(KIND_VERDICT, 16'd0, 16'd0, 32'd0, 1'b1, 1'b0)});
      directed.push_back('{OP_SEND, 16'd0, 16'd0, 32'd0, 1'b1, 1'b1,
                           typed_row(KIND_STAMP, 16'd1, 16'd0, 32'd0, 1'b0, 1'b0)});
      directed.push_back('{OP_SEND, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, none});
      directed.push_back('{OP_RECEIVE, 16'd1, 16'd0, 32'd0, 1'b0, 1'b1,
                           typed_row(KIND_VERDICT, 16'd1, 16'd1, 32'd1, 1'b0, 1'b0)});
      // Jump by exactly 32: older bits cleared, old latest at bit 31.
      directed.push_back('{OP_RECEIVE, 16'd33, 16'd2, 32'd1, 1'b0, 1'b1,
                           typed_row(KIND_VERDICT, 16'd33, 16'd33, 32'h8000_0000,
                                     1'b0, 1'b0)});
      directed.push_back('{OP_RECEIVE, 16'd1, 16'd0, 32'd0, 1'b0, 1'b0, none});
      directed.push_back('{OP_RECEIVE, 16'd30, 16'd0, 32'd0, 1'b0, 1'b0, none});
      directed.push_back('{OP_RECEIVE, 16'd30, 16'd0, 32'd0, 1'b0, 1'b0, none});
      directed.push_back('{OP_RECEIVE, 16'd0, 16'd0, 32'd0, 1'b0, 1'b0, none});
      // Half-range distance: too old, state kept.
      directed.push_back('{OP_RECEIVE, 16'd33 + 16'd32768, 16'hFFFF, 32'hFFFF_FFFF,
                           1'b0, 1'b0, none});
      directed.push_back('{OP_RECEIVE, 16'hFFFF - 16'd10, 16'h0000, 32'h0, 1'b0, 1'b0, none});
      directed.push_back('{OP_RECEIVE, 16'd33 + 16'd32767, 16'h5A5A, 32'hA5A5_A5A5,
                           1'b0, 1'b0, none});
      directed.push_back('{OP_SEND, 16'd0, 16'd0, 32'd0, 1'b0, 1'b0, none});
      directed.push_back('{OP_TICK, 16'd0, 16'd0, 32'd0, 1'b0, 1'b0, none});
      directed.push_back('{OP_UNUSED, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, none});
      directed.push_back('{OP_UNUSED, 16'h0, 16'h0, 32'h0, 1'b0, 1'b0, none});

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed phase under reset register values.
      foreach (directed[i])
         send_item(directed[i].op, directed[i].seq, directed[i].ack, directed[i].bits,
                   directed[i].reliable, directed[i].has_expect, directed[i].want);
      drain();

      // Zero timeout with no retries: every tick expires and gives up.
      write_register(CSR_TIMEOUT, 10'd0);
      write_register(CSR_MAX_RETRIES, 10'd0);
      for (int i = 0; i < 36; i++) send_item(OP_SEND, '0, '0, '0, 1'b1, 1'b0, none);
      send_item(OP_SEND, '0, '0, '0, 1'b1, 1'b0, none);  // replaces nothing; full
      send_item(OP_TICK, '0, '0, '0, 1'b0, 1'b0, none);  // result cap
      send_item(OP_TICK, '0, '0, '0, 1'b0, 1'b0, none);
      drain();

      // Short timeout, a few retries: frequent retransmit traffic.
      write_register(CSR_TIMEOUT, 10'd1);
      write_register(CSR_MAX_RETRIES, 10'd2);
      random_items(110);
      drain();

      // Ack-freeing phase with a full retry budget.
      write_register(CSR_TIMEOUT, 10'd3);
      write_register(CSR_MAX_RETRIES, 10'd15);
      random_items(80);
      drain();

      // Largest timeout; final stretch with no idling on either side.
      write_register(CSR_TIMEOUT, 10'd1023);
      sender_idle_on = 1'b0;
      stall_off = 1'b1;
      random_items(40);
      drain();

      $display("covered %0d items, %0d results: %0d retransmits, %0d given up,",
               item_count, result_count, retx_count, giveup_count);
      $display("  %0d duplicate verdicts, %0d table-full stamps", dup_count, full_count);
      if (error_count == 0)
         $display("tb_reliable_datagram_ack_window_core passed");
      else
         $display("tb_reliable_datagram_ack_window_core failed");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/rdaw_pkg.sv
rtl/rdaw_front.sv
rtl/rdaw_back.sv
rtl/reliable_datagram_ack_window_core.sv
rtl/rdaw_checker.sv
bench/tb_reliable_datagram_ack_window_core.sv
